// ===== src/assert_macros.svh =====
// Assertion macros shared by the keyed table RTL.
// Each macro expects clk and rst_n in scope; NO_ASSERTIONS strips them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define KTO_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define KTO_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define KTO_ASSERT_IMP(lbl, a, c)
`define KTO_ASSERT_NXT(lbl, a, c)
`endif
`endif

// ===== src/kto_pkg.sv =====
// Shared types and constants for the keyed table with oldest-entry eviction.
// No dependencies; used by kto_cell and the top level.
`timescale 1ns / 1ps
package kto_pkg;

  localparam int MAX_NODES = 64;
  localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int KEY_W     = 64;
  localparam int TIME_W    = 40;
  localparam int SLOT_W    = 6;
  localparam int COUNT_W   = 7;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_MARK   = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  // search word that walks down the cell chain
  typedef struct packed {
    cmd_t              cmd;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stime;
    logic              found;
    logic [IDX_W-1:0]  found_slot;
    logic [IDX_W-1:0]  pick_slot;
    logic [TIME_W-1:0] pick_time;
    logic [KEY_W-1:0]  pick_key;
  } search_t;

  // update broadcast to all cells
  typedef struct packed {
    logic              key_en;    // new key: write key and clear mark
    logic              time_en;
    logic              set_mark;
    logic [IDX_W-1:0]  slot;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stime;
  } wr_t;

endpackage

// ===== src/kto_cell.sv =====
// One table slot: key, time and reported mark, plus one stage of the search chain.
// Depends on kto_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kto_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [kto_pkg::IDX_W-1:0]   cell_idx,
  input  logic [kto_pkg::CNT_W-1:0]   fill_count,
  input  logic                        tok_in_v,
  input  kto_pkg::search_t            tok_in,
  output logic                        tok_out_v,
  output kto_pkg::search_t            tok_out,
  input  kto_pkg::wr_t                wr
);

  logic [kto_pkg::KEY_W-1:0]  key_r;
  logic [kto_pkg::TIME_W-1:0] time_r;
  logic                       mark_r;
  logic                       tok_v_r;
  kto_pkg::search_t           tok_r;
  kto_pkg::search_t           tok_nxt;
  logic                       filled;
  logic                       sel;

  assign filled = kto_pkg::CNT_W'(cell_idx) < fill_count;
  assign sel    = (wr.slot == cell_idx);

  always_comb begin
    tok_nxt = tok_in;
    if (filled && !tok_in.found && (key_r == tok_in.key)) begin
      tok_nxt.found      = 1'b1;
      tok_nxt.found_slot = cell_idx;
    end
    // slot 0 seeds the pick, later slots replace it only if strictly older and unreported
    if (cell_idx == '0) begin
      tok_nxt.pick_slot = cell_idx;
      tok_nxt.pick_time = time_r;
      tok_nxt.pick_key  = key_r;
    end else if (filled && !mark_r && (time_r < tok_in.pick_time)) begin
      tok_nxt.pick_slot = cell_idx;
      tok_nxt.pick_time = time_r;
      tok_nxt.pick_key  = key_r;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (sel && wr.key_en) begin
      key_r <= wr.key;
    end
    if (sel && wr.time_en) begin
      time_r <= wr.stime;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
      mark_r  <= 1'b0;
    end else begin
      tok_v_r <= tok_in_v;
      if (sel && wr.key_en) begin
        mark_r <= 1'b0;
      end else if (sel && wr.set_mark) begin
        mark_r <= 1'b1;
      end
    end
  end

  assign tok_out_v = tok_v_r;
  assign tok_out   = tok_r;

  `KTO_ASSERT_NXT(a_mark_set, sel && wr.set_mark && !wr.key_en, mark_r)
  `KTO_ASSERT_NXT(a_mark_clr, sel && wr.key_en, !mark_r)
  `KTO_ASSERT_NXT(a_key_wr, sel && wr.key_en, key_r == $past(wr.key))

endmodule

// ===== src/keyed_table_oldest_eviction.sv =====
// A word passes the MAX_NODES cell registers, fin_r and then the output register.
// A new word is accepted only once the previous one finishes; the search word walks the
// cell chain one slot per cycle, so the chain length sets how long each word takes.
// A stalled result sits in the output register while the next word is scanned.
// Reset (synchronous, rst_n low): table empty, reported marks clear, no word in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module keyed_table_oldest_eviction (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_command,
  input  logic [kto_pkg::KEY_W-1:0]     in_node_key,
  input  logic [kto_pkg::TIME_W-1:0]    in_send_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kto_pkg::SLOT_W-1:0]    out_slot,
  output logic                          out_hit,
  output logic                          out_evicted,
  output logic [kto_pkg::KEY_W-1:0]     out_evicted_key,
  output logic [kto_pkg::COUNT_W-1:0]   out_entry_count
);

  localparam int N = kto_pkg::MAX_NODES;

  logic                               busy_r;
  logic                               fin_v_r;
  kto_pkg::search_t                   fin_r;
  logic [kto_pkg::CNT_W-1:0]          fill_r;
  logic [kto_pkg::CNT_W-1:0]          fill_nxt;
  logic                               out_v_r;
  logic [kto_pkg::SLOT_W-1:0]         slot_r;
  logic                               hit_r;
  logic                               evicted_r;
  logic [kto_pkg::KEY_W-1:0]          ev_key_r;
  logic [kto_pkg::COUNT_W-1:0]        count_r;

  logic                               tv [0:N];
  kto_pkg::search_t                   tok [0:N];
  kto_pkg::wr_t                       wr;
  logic                               finish;
  logic                               full;
  logic [kto_pkg::IDX_W-1:0]          res_slot;
  logic                               res_evicted;
  logic [kto_pkg::KEY_W-1:0]          res_ev_key;

  assign in_ready = !busy_r;
  assign full     = (fill_r == kto_pkg::CNT_W'(N));
  assign finish   = fin_v_r && (!out_v_r || out_ready);

  always_comb begin
    tv[0]            = in_valid && in_ready;
    tok[0].cmd       = kto_pkg::cmd_t'(in_command);
    tok[0].key       = in_node_key;
    tok[0].stime     = in_send_time;
    tok[0].found     = 1'b0;
    tok[0].found_slot = '0;
    tok[0].pick_slot = '0;
    tok[0].pick_time = '0;
    tok[0].pick_key  = '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    kto_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (kto_pkg::IDX_W'(i)),
      .fill_count (fill_r),
      .tok_in_v   (tv[i]),
      .tok_in     (tok[i]),
      .tok_out_v  (tv[i+1]),
      .tok_out    (tok[i+1]),
      .wr         (wr)
    );
  end

  // resolve the finished search into a result and a table update
  always_comb begin
    wr          = '0;
    wr.key      = fin_r.key;
    wr.stime    = fin_r.stime;
    fill_nxt    = fill_r;
    res_evicted = 1'b0;
    res_ev_key  = '0;
    res_slot    = fin_r.found ? fin_r.found_slot : '0;
    unique case (fin_r.cmd)
      kto_pkg::CMD_PUT: begin
        if (fin_r.found) begin
          wr.time_en = finish;
        end else begin
          if (!full) begin
            res_slot = fill_r[kto_pkg::IDX_W-1:0];
            fill_nxt = fill_r + kto_pkg::CNT_W'(1);
          end else begin
            res_slot    = fin_r.pick_slot;
            res_evicted = 1'b1;
            res_ev_key  = fin_r.pick_key;
          end
          wr.key_en  = finish;
          wr.time_en = finish;
        end
      end
      kto_pkg::CMD_MARK: begin
        wr.set_mark = finish && fin_r.found;
      end
      kto_pkg::CMD_LOOKUP, kto_pkg::CMD_RSVD: begin
      end
      default: begin
      end
    endcase
    wr.slot = res_slot;
  end

  always_ff @(posedge clk) begin
    if (tv[N]) begin
      fin_r <= tok[N];
    end
    if (finish) begin
      slot_r    <= kto_pkg::SLOT_W'(res_slot);
      hit_r     <= fin_r.found;
      evicted_r <= res_evicted;
      ev_key_r  <= res_ev_key;
      count_r   <= kto_pkg::COUNT_W'(fill_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      fin_v_r <= 1'b0;
      out_v_r <= 1'b0;
      fill_r  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        busy_r <= 1'b1;
      end else if (finish) begin
        busy_r <= 1'b0;
      end
      if (tv[N]) begin
        fin_v_r <= 1'b1;
      end else if (finish) begin
        fin_v_r <= 1'b0;
      end
      if (finish) begin
        out_v_r <= 1'b1;
        fill_r  <= fill_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_slot        = slot_r;
  assign out_hit         = hit_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_key = ev_key_r;
  assign out_entry_count = count_r;

  `KTO_ASSERT_IMP(a_fin_busy, fin_v_r, busy_r)
  `KTO_ASSERT_IMP(a_fill_range, 1'b1, fill_r <= kto_pkg::CNT_W'(N))
  `KTO_ASSERT_IMP(a_evict_full, finish && res_evicted, full && !fin_r.found)
  `KTO_ASSERT_NXT(a_fill_step, finish && fin_r.cmd == kto_pkg::CMD_PUT && !fin_r.found && !full,
                  fill_r == $past(fill_r) + kto_pkg::CNT_W'(1))

endmodule
